FILE: rtl/core/pla_pkg.sv
// pla_pkg: shared types and constants for the point light radiance core
// cell state structs, register index codes, reset values
// no dependencies
package pla_pkg;

  localparam int unsigned SQRT_STEPS = 48;
  localparam int unsigned DIV_STEPS  = 16;
  localparam int unsigned PRE_STAGES = 3;
  localparam int unsigned MID_STAGES = 7;
  localparam int unsigned PIPE_DEPTH = PRE_STAGES + SQRT_STEPS + MID_STAGES + DIV_STEPS + 1;

  localparam int unsigned SQ_X_W   = 2 * SQRT_STEPS;
  localparam int unsigned SQ_REM_W = SQRT_STEPS + 2;
  localparam int unsigned DIV_W    = 61;
  localparam int unsigned LANES    = 6;

  typedef enum logic [2:0] {
    REG_LIGHT_X   = 3'd0,
    REG_LIGHT_Y   = 3'd1,
    REG_LIGHT_Z   = 3'd2,
    REG_INTENSITY = 3'd3,
    REG_ATT_CONST = 3'd4,
    REG_ATT_LIN   = 3'd5,
    REG_ATT_QUAD  = 3'd6,
    REG_COLOR     = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [SQ_X_W-1:0]     x;
    logic [SQ_REM_W-1:0]   rem;
    logic [SQRT_STEPS-1:0] root;
  } sqrt_st_t;

  typedef struct packed {
    logic [DIV_W-1:0]     dvs;
    logic [DIV_W-1:0]     rem;
    logic [DIV_STEPS-1:0] nlo;
    logic [DIV_STEPS-1:0] quo;
  } div_st_t;

  localparam logic [31:0] LIGHT_X_RST   = 32'h0000_0000;
  localparam logic [31:0] LIGHT_Y_RST   = 32'h0001_0000;
  localparam logic [31:0] LIGHT_Z_RST   = 32'h0000_0000;
  localparam logic [15:0] INTENSITY_RST = 16'h0100;
  localparam logic [15:0] ATT_CONST_RST = 16'h0000;
  localparam logic [15:0] ATT_LIN_RST   = 16'h0100;
  localparam logic [15:0] ATT_QUAD_RST  = 16'h0000;
  localparam logic [47:0] COLOR_RST     = 48'h0100_0100_0100;

  localparam logic [15:0] DIR_ONE = 16'd16384;
  localparam logic [15:0] CH_MAX  = 16'hFFFF;

endpackage

FILE: rtl/core/pla_if.sv
// pla_in_if / pla_out_if: valid-ready channels of the point light core
// hit point beats in, shaded result beats out; no dependencies
interface pla_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] hit_x;
  logic signed [31:0] hit_y;
  logic signed [31:0] hit_z;
  modport source (output valid, hit_x, hit_y, hit_z, input ready);
  modport sink   (input valid, hit_x, hit_y, hit_z, output ready);
endinterface

interface pla_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;
  logic [15:0]        rad_red;
  logic [15:0]        rad_green;
  logic [15:0]        rad_blue;
  logic               zero_distance;
  logic               saturated;
  modport source (output valid, dir_x, dir_y, dir_z, rad_red, rad_green, rad_blue,
                  zero_distance, saturated, input ready);
  modport sink   (input valid, dir_x, dir_y, dir_z, rad_red, rad_green, rad_blue,
                  zero_distance, saturated, output ready);
endinterface

FILE: rtl/core/point_light_attenuated_radiance.sv
// point_light_attenuated_radiance: point light direction and attenuated radiance
// depends on pla_pkg, pla_in_if, pla_out_if, pla_sqrt_cell, pla_div_cell
//
//  channel | dir | beat contents
//  in_chan | in  | hit_x, hit_y, hit_z (Q16.16)
//  out_chan| out | dir_x/y/z (Q1.14), rad_red/green/blue (Q8.8), zero_distance, saturated
//  cfg_*   | in  | register index and write data, taken on cfg_we
//
// one beat per cycle while the output is not stalled; the pipeline is set by the 48-cell square root
// chain and the 16-cell division chains
// rst_n is synchronous: clears pipeline valid bits and loads register defaults
// a stalled output freezes the whole pipeline; in_chan.ready follows that stall
module point_light_attenuated_radiance (
  input  logic        clk,
  input  logic        rst_n,
  pla_in_if.sink      in_chan,
  pla_out_if.source   out_chan,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [47:0] cfg_wdata
);
  localparam int unsigned NS = pla_pkg::SQRT_STEPS;
  localparam int unsigned ND = pla_pkg::DIV_STEPS;
  localparam int unsigned NL = pla_pkg::LANES;
  localparam int unsigned PD = pla_pkg::PIPE_DEPTH;
  localparam logic [60:0] QUAD_CAP = 61'd1 << 60;

  typedef struct packed {
    logic [2:0]       neg;
    logic [2:0][31:0] mag;
  } s1_t;

  typedef struct packed {
    logic [2:0]       neg;
    logic [2:0][31:0] mag;
    logic [2:0][63:0] sq;
  } s2_t;

  typedef struct packed {
    logic [2:0]       neg;
    logic [2:0][31:0] mag;
    logic             zero;
  } sside_t;

  typedef struct packed {
    logic [2:0]       neg;
    logic             zero;
    logic [46:0]      df;
    logic [2:0][60:0] nd;
    logic [2:0][31:0] num;
    logic [31:0]      hh;
    logic [32:0]      hl;
    logic [33:0]      ll;
    logic [48:0]      lin;
    logic [65:0]      sq;
    logic [48:0]      pa;
    logic [48:0]      pb;
    logic [60:0]      quad;
    logic [60:0]      den;
    logic [2:0][60:0] nr;
  } mid_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
    logic       dz;
    logic [2:0] ovf;
  } dside_t;

  typedef struct packed {
    logic [2:0][15:0] dir;
    logic [2:0][15:0] rad;
    logic             zero;
    logic             sat;
  } out_t;

  // configuration registers
  logic signed [31:0] light_x_r, light_y_r, light_z_r;
  logic [15:0] intensity_r, att_c_r, att_l_r, att_q_r;
  logic [47:0] color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_x_r   <= pla_pkg::LIGHT_X_RST;
      light_y_r   <= pla_pkg::LIGHT_Y_RST;
      light_z_r   <= pla_pkg::LIGHT_Z_RST;
      intensity_r <= pla_pkg::INTENSITY_RST;
      att_c_r     <= pla_pkg::ATT_CONST_RST;
      att_l_r     <= pla_pkg::ATT_LIN_RST;
      att_q_r     <= pla_pkg::ATT_QUAD_RST;
      color_r     <= pla_pkg::COLOR_RST;
    end else if (cfg_we) begin
      unique case (pla_pkg::cfg_reg_t'(cfg_idx))
        pla_pkg::REG_LIGHT_X:   light_x_r   <= cfg_wdata[31:0];
        pla_pkg::REG_LIGHT_Y:   light_y_r   <= cfg_wdata[31:0];
        pla_pkg::REG_LIGHT_Z:   light_z_r   <= cfg_wdata[31:0];
        pla_pkg::REG_INTENSITY: intensity_r <= cfg_wdata[15:0];
        pla_pkg::REG_ATT_CONST: att_c_r     <= cfg_wdata[15:0];
        pla_pkg::REG_ATT_LIN:   att_l_r     <= cfg_wdata[15:0];
        pla_pkg::REG_ATT_QUAD:  att_q_r     <= cfg_wdata[15:0];
        pla_pkg::REG_COLOR:     color_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic          adv, in_acc;
  logic [PD-1:0] vld_r;

  assign adv           = !vld_r[PD-1] || out_chan.ready;
  assign in_acc        = in_chan.valid && adv;
  assign in_chan.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PD-2:0], in_acc};
    end
  end

  // stage 1: differences toward the light, sign and magnitude
  logic [32:0] dif [3];
  s1_t s1_nxt, s1_r;

  always_comb begin
    dif[0] = {light_x_r[31], light_x_r} - {in_chan.hit_x[31], in_chan.hit_x};
    dif[1] = {light_y_r[31], light_y_r} - {in_chan.hit_y[31], in_chan.hit_y};
    dif[2] = {light_z_r[31], light_z_r} - {in_chan.hit_z[31], in_chan.hit_z};
    for (int i = 0; i < 3; i++) begin
      s1_nxt.neg[i] = dif[i][32];
      s1_nxt.mag[i] = dif[i][32] ? 32'(~dif[i] + 33'd1) : dif[i][31:0];
    end
  end

  // stage 2: squares
  s2_t s2_nxt, s2_r;

  always_comb begin
    s2_nxt.neg = s1_r.neg;
    s2_nxt.mag = s1_r.mag;
    for (int i = 0; i < 3; i++) begin
      s2_nxt.sq[i] = 64'(s1_r.mag[i]) * 64'(s1_r.mag[i]);
    end
  end

  // stage 3: sum of squares, scaled radicand for the root chain
  logic [65:0]       sum3;
  pla_pkg::sqrt_st_t sst0_nxt, sst0_r;
  sside_t            sside0_nxt, sside0_r;

  always_comb begin
    sum3 = 66'(s2_r.sq[0]) + 66'(s2_r.sq[1]) + 66'(s2_r.sq[2]);
    sst0_nxt.x    = {2'b00, sum3, 28'd0};
    sst0_nxt.rem  = '0;
    sst0_nxt.root = '0;
    sside0_nxt.neg  = s2_r.neg;
    sside0_nxt.mag  = s2_r.mag;
    sside0_nxt.zero = (sum3 == '0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r     <= s1_nxt;
      s2_r     <= s2_nxt;
      sst0_r   <= sst0_nxt;
      sside0_r <= sside0_nxt;
    end
  end

  // square root chain
  pla_pkg::sqrt_st_t sst [NS];
  sside_t            sside_r [NS];

  for (genvar gi = 0; gi < NS; gi++) begin : g_sqrt
    if (gi == 0) begin : g_first
      pla_sqrt_cell u_cell (.clk(clk), .en(adv), .st_i(sst0_r), .st_o(sst[gi]));
      always_ff @(posedge clk) begin
        if (adv) begin
          sside_r[gi] <= sside0_r;
        end
      end
    end else begin : g_next
      pla_sqrt_cell u_cell (.clk(clk), .en(adv), .st_i(sst[gi-1]), .st_o(sst[gi]));
      always_ff @(posedge clk) begin
        if (adv) begin
          sside_r[gi] <= sside_r[gi-1];
        end
      end
    end
  end

  // stages 4..9: denominator, numerators
  logic [46:0] df4;
  logic [32:0] d16;
  logic [15:0] dh;
  logic [16:0] dl;
  logic [81:0] prod7;
  mid_t mid_nxt [6];
  mid_t mid_r [6];

  always_comb begin
    df4 = sst[NS-1].root[46:0];
    d16 = df4[46:14];
    dh  = d16[32:17];
    dl  = d16[16:0];

    mid_nxt[0]      = '0;
    mid_nxt[0].neg  = sside_r[NS-1].neg;
    mid_nxt[0].zero = sside_r[NS-1].zero;
    mid_nxt[0].df   = df4;
    mid_nxt[0].hh   = 32'(dh) * 32'(dh);
    mid_nxt[0].hl   = 33'(dh) * 33'(dl);
    mid_nxt[0].ll   = 34'(dl) * 34'(dl);
    mid_nxt[0].lin  = 49'(att_l_r) * 49'(d16);
    for (int i = 0; i < 3; i++) begin
      mid_nxt[0].nd[i]  = 61'({sside_r[NS-1].mag[i], 28'd0}) + 61'(df4[46:1]);
      mid_nxt[0].num[i] = 32'(intensity_r) * 32'(color_r[47-16*i -: 16]);
    end

    mid_nxt[1]    = mid_r[0];
    mid_nxt[1].sq = 66'({mid_r[0].hh, 34'd0}) + 66'({mid_r[0].hl, 18'd0})
                  + 66'(mid_r[0].ll);

    mid_nxt[2]    = mid_r[1];
    mid_nxt[2].pa = 49'(att_q_r) * 49'(mid_r[1].sq[32:0]);
    mid_nxt[2].pb = 49'(att_q_r) * 49'(mid_r[1].sq[65:33]);

    // quadratic term, capped where it already drives every channel to zero
    prod7         = {mid_r[2].pb, 33'd0} + 82'(mid_r[2].pa);
    mid_nxt[3]    = mid_r[2];
    mid_nxt[3].quad = (prod7[81:16] > 66'(QUAD_CAP)) ? QUAD_CAP : prod7[76:16];

    mid_nxt[4]     = mid_r[3];
    mid_nxt[4].den = 61'({att_c_r, 16'd0}) + 61'(mid_r[3].lin) + mid_r[3].quad;

    mid_nxt[5] = mid_r[4];
    for (int i = 0; i < 3; i++) begin
      mid_nxt[5].nr[i] = 61'({mid_r[4].num[i], 16'd0}) + 61'(mid_r[4].den[60:1]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 6; k++) begin
        mid_r[k] <= mid_nxt[k];
      end
    end
  end

  // stage 10: overflow test, division chain setup
  pla_pkg::div_st_t dinit_nxt [NL];
  pla_pkg::div_st_t dinit_r [NL];
  dside_t dside0_nxt, dside0_r;

  always_comb begin
    dside0_nxt.neg  = mid_r[5].neg;
    dside0_nxt.zero = mid_r[5].zero;
    dside0_nxt.dz   = (mid_r[5].den == '0);
    for (int i = 0; i < 3; i++) begin
      dside0_nxt.ovf[i] = {16'd0, mid_r[5].nr[i]} >= {mid_r[5].den, 16'd0};
      dinit_nxt[i].dvs   = 61'(mid_r[5].df);
      dinit_nxt[i].rem   = 61'(mid_r[5].nd[i][60:16]);
      dinit_nxt[i].nlo   = mid_r[5].nd[i][15:0];
      dinit_nxt[i].quo   = '0;
      dinit_nxt[i+3].dvs = mid_r[5].den;
      dinit_nxt[i+3].rem = 61'(mid_r[5].nr[i][60:16]);
      dinit_nxt[i+3].nlo = mid_r[5].nr[i][15:0];
      dinit_nxt[i+3].quo = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dside0_r <= dside0_nxt;
      for (int j = 0; j < NL; j++) begin
        dinit_r[j] <= dinit_nxt[j];
      end
    end
  end

  // division chains: three direction lanes, three radiance lanes
  pla_pkg::div_st_t dst [ND][NL];
  dside_t           dside_r [ND];

  for (genvar gk = 0; gk < ND; gk++) begin : g_div
    if (gk == 0) begin : g_first
      for (genvar gj = 0; gj < NL; gj++) begin : g_lane
        pla_div_cell u_cell (.clk(clk), .en(adv), .st_i(dinit_r[gj]), .st_o(dst[gk][gj]));
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          dside_r[gk] <= dside0_r;
        end
      end
    end else begin : g_next
      for (genvar gj = 0; gj < NL; gj++) begin : g_lane
        pla_div_cell u_cell (.clk(clk), .en(adv), .st_i(dst[gk-1][gj]),
                             .st_o(dst[gk][gj]));
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          dside_r[gk] <= dside_r[gk-1];
        end
      end
    end
  end

  // output register
  logic [15:0] qc [3];
  out_t out_nxt, out_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i] = (dst[ND-1][i].quo > pla_pkg::DIR_ONE) ? pla_pkg::DIR_ONE : dst[ND-1][i].quo;
      if (dside_r[ND-1].zero) begin
        out_nxt.dir[i] = '0;
      end else if (dside_r[ND-1].neg[i]) begin
        out_nxt.dir[i] = ~qc[i] + 16'd1;
      end else begin
        out_nxt.dir[i] = qc[i];
      end
      out_nxt.rad[i] = (dside_r[ND-1].dz || dside_r[ND-1].ovf[i]) ? pla_pkg::CH_MAX
                                                                   : dst[ND-1][i+3].quo;
    end
    out_nxt.zero = dside_r[ND-1].zero;
    out_nxt.sat  = dside_r[ND-1].dz || (|dside_r[ND-1].ovf);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_chan.valid         = vld_r[PD-1];
  assign out_chan.dir_x         = out_r.dir[0];
  assign out_chan.dir_y         = out_r.dir[1];
  assign out_chan.dir_z         = out_r.dir[2];
  assign out_chan.rad_red       = out_r.rad[0];
  assign out_chan.rad_green     = out_r.rad[1];
  assign out_chan.rad_blue      = out_r.rad[2];
  assign out_chan.zero_distance = out_r.zero;
  assign out_chan.saturated     = out_r.sat;
endmodule

FILE: rtl/core/pla_sqrt_cell.sv
// pla_sqrt_cell: one restoring square root step, two radicand bits per cell
// depends on pla_pkg
module pla_sqrt_cell (
  input  logic              clk,
  input  logic              en,
  input  pla_pkg::sqrt_st_t st_i,
  output pla_pkg::sqrt_st_t st_o
);
  localparam int unsigned RMW = pla_pkg::SQ_REM_W;
  localparam int unsigned EXW = pla_pkg::SQ_REM_W + 2;
  localparam int unsigned XW  = pla_pkg::SQ_X_W;
  localparam int unsigned RTW = pla_pkg::SQRT_STEPS;

  pla_pkg::sqrt_st_t st_r, st_nxt;
  logic [EXW-1:0] rem_ext, trial, diff;

  always_comb begin
    rem_ext = {st_i.rem, st_i.x[XW-1 -: 2]};
    trial   = {2'b00, st_i.root, 2'b01};
    diff    = rem_ext - trial;
    st_nxt.x = {st_i.x[XW-3:0], 2'b00};
    if (rem_ext >= trial) begin
      st_nxt.rem  = diff[RMW-1:0];
      st_nxt.root = {st_i.root[RTW-2:0], 1'b1};
    end else begin
      st_nxt.rem  = rem_ext[RMW-1:0];
      st_nxt.root = {st_i.root[RTW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign st_o = st_r;
endmodule

FILE: rtl/core/pla_div_cell.sv
// pla_div_cell: one restoring division step, one quotient bit per cell
// depends on pla_pkg
module pla_div_cell (
  input  logic             clk,
  input  logic             en,
  input  pla_pkg::div_st_t st_i,
  output pla_pkg::div_st_t st_o
);
  localparam int unsigned DW = pla_pkg::DIV_W;
  localparam int unsigned QW = pla_pkg::DIV_STEPS;

  pla_pkg::div_st_t st_r, st_nxt;
  logic [DW:0] trial, diff;

  always_comb begin
    trial  = {st_i.rem, st_i.nlo[QW-1]};
    diff   = trial - {1'b0, st_i.dvs};
    st_nxt = st_i;
    st_nxt.nlo = {st_i.nlo[QW-2:0], 1'b0};
    if (trial >= {1'b0, st_i.dvs}) begin
      st_nxt.rem = diff[DW-1:0];
      st_nxt.quo = {st_i.quo[QW-2:0], 1'b1};
    end else begin
      st_nxt.rem = trial[DW-1:0];
      st_nxt.quo = {st_i.quo[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign st_o = st_r;
endmodule

FILE: rtl/core/pla_checker.sv
// pla_checker: port-level checks on the point light radiance core
// bound to point_light_attenuated_radiance; no other dependencies
module pla_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] dir_x,
  input logic signed [15:0] dir_y,
  input logic signed [15:0] dir_z,
  input logic [15:0]        rad_red,
  input logic [15:0]        rad_green,
  input logic [15:0]        rad_blue,
  input logic               zero_distance,
  input logic               saturated
);
  // a held beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({dir_x, dir_y, dir_z, rad_red,
      rad_green, rad_blue, zero_distance, saturated}))
    else $error("output beat changed while stalled");

  // input side only stalls behind a full, stalled output
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |-> (in_ready == (!out_valid || out_ready)))
    else $error("input ready does not track output stall");

  a_zero_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && zero_distance |-> dir_x == 16'sd0 && dir_y == 16'sd0 && dir_z == 16'sd0)
    else $error("nonzero direction at zero distance");

  a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> dir_x <= 16'sd16384 && dir_x >= -16'sd16384
               && dir_y <= 16'sd16384 && dir_y >= -16'sd16384
               && dir_z <= 16'sd16384 && dir_z >= -16'sd16384)
    else $error("direction component beyond unit length");
endmodule

bind point_light_attenuated_radiance pla_checker u_pla_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .dir_x         (out_chan.dir_x),
  .dir_y         (out_chan.dir_y),
  .dir_z         (out_chan.dir_z),
  .rad_red       (out_chan.rad_red),
  .rad_green     (out_chan.rad_green),
  .rad_blue      (out_chan.rad_blue),
  .zero_distance (out_chan.zero_distance),
  .saturated     (out_chan.saturated)
);
